>>> sv/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// shared types and constants of the sprite frame sequencer
// ----------------------------------------------------------------------------
package sfs_pkg;

  // operation codes carried in s_tuser
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_STOP   = 3'd2;
  localparam logic [2:0] OP_PAUSE  = 3'd3;
  localparam logic [2:0] OP_RESUME = 3'd4;
  localparam logic [2:0] OP_LOAD   = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_FRAMES_ACROSS = 3'd2;
  localparam logic [2:0] REG_FRAME_PERIOD  = 3'd3;
  localparam logic [2:0] REG_RANGE_START   = 3'd4;
  localparam logic [2:0] REG_RANGE_END     = 3'd5;
  localparam logic [2:0] REG_PLAY_MODE     = 3'd6;
  localparam logic [2:0] REG_CUSTOM_LENGTH = 3'd7;

  // play_mode bits
  localparam int MODE_PINGPONG = 0;
  localparam int MODE_LOOP     = 1;
  localparam int MODE_CUSTOM   = 2;

  localparam logic [16:0] ACCUM_MAX = 17'h1FFFF;

  // request to the coordinate unit
  typedef struct packed {
    logic [5:0] frame;
    logic [6:0] across;
    logic [9:0] width;
    logic [9:0] height;
  } coord_req_t;

  // result of the coordinate unit
  typedef struct packed {
    logic        done;
    logic [15:0] x;
    logic [15:0] y;
  } coord_rsp_t;

endpackage

>>> sv/sprite_frame_sequencer.sv
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// sprite sheet animation sequencer with range and custom-table play lists
// ----------------------------------------------------------------------------
// Each request on the slave stream (tick, start, stop, pause, resume or table
// load) gives exactly one result on the master stream: the frame at the play
// position, its sheet x/y, the playing flag and the position. Requests are
// handled one at a time; a request passes from acceptance to result through
// four control steps (update, advance, position with the table read, frame
// select), the bit-serial column/row split in the coordinate unit, which
// works through the six bits of the frame number in turn, the two products,
// the hand-back of the coordinates and the load of the output register. The
// next request can be taken in the cycle after that load. The result sits in
// an output register, so the next request is taken while it waits. The custom
// table is a synchronous memory of MAX_FRAMES entries; entries read before
// they are written return undefined data. Configuration is written through
// the cfg channel, which is always ready; the user must write it only while
// no request is in flight, and the block itself has no check for this.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer
  import sfs_pkg::*;
#(
  parameter int MAX_FRAMES = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // elapsed[15:0], entry_index[21:16], entry_value[27:22]
  input  logic [2:0]  s_tuser,   // operation
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // frame_number[5:0], frame_x[21:6], frame_y[37:22],
                                 // playing[38], play_position[45:39]
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW        = $clog2(MAX_FRAMES);
  localparam int LEN_CLAMP = (MAX_FRAMES > 127) ? 127 : MAX_FRAMES;

  // one-hot sequence of a request
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_ADV   = 7'b0000100,
    S_POS   = 7'b0001000,
    S_FRAME = 7'b0010000,
    S_COORD = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;

  // configuration registers
  logic [9:0]  frame_width;
  logic [9:0]  frame_height;
  logic [6:0]  frames_across;
  logic [15:0] frame_period;
  logic [5:0]  range_start;
  logic [5:0]  range_end;
  logic [2:0]  play_mode;
  logic [6:0]  custom_length;

  // animation state
  logic [16:0] time_accum;
  logic [6:0]  play_index;
  logic        running;

  // captured request
  logic [2:0]  op;
  logic [15:0] elapsed;
  logic [5:0]  entry_index;
  logic [5:0]  entry_value;

  // work registers
  logic [6:0]  list_len;
  logic        adv_pending;
  logic [6:0]  pos;
  logic [5:0]  frame;

  // play list length, from configuration alone
  logic        range_up;
  logic [5:0]  span;
  logic [6:0]  len_next;

  assign range_up = range_start <= range_end;
  assign span     = range_up ? (range_end - range_start) : (range_start - range_end);

  always_comb begin
    if (play_mode[MODE_CUSTOM]) begin
      if (custom_length == 7'd0) begin
        len_next = 7'd1;
      end else if (int'(custom_length) > LEN_CLAMP) begin
        len_next = 7'(LEN_CLAMP);
      end else begin
        len_next = custom_length;
      end
    end else if (span == 6'd0) begin
      len_next = 7'd0;                        // empty range
    end else if (!play_mode[MODE_PINGPONG]) begin
      len_next = {1'b0, span} + 7'd1;
    end else if (play_mode[MODE_LOOP]) begin
      len_next = {span, 1'b0};                // final return to the range start dropped
    end else begin
      len_next = {span, 1'b0} + 7'd1;
    end
  end

  // saturating accumulate
  logic [17:0] accum_sum;
  logic [16:0] accum_sat;
  assign accum_sum = {1'b0, time_accum} + {2'b0, elapsed};
  assign accum_sat = accum_sum[17] ? ACCUM_MAX : accum_sum[16:0];

  logic [7:0] index_inc;
  assign index_inc = {1'b0, play_index} + 8'd1;

  // range frame from the clamped position
  logic [6:0] back_steps;
  logic [5:0] range_frame;
  assign back_steps = pos - {1'b0, span};

  always_comb begin
    if (pos <= {1'b0, span}) begin
      range_frame = range_up ? (range_start + pos[5:0]) : (range_start - pos[5:0]);
    end else begin
      range_frame = range_up ? (range_end - back_steps[5:0]) : (range_end + back_steps[5:0]);
    end
  end

  // custom table
  logic       tbl_wr;
  logic       tbl_rd;
  logic [5:0] tbl_data;

  assign tbl_wr = (state == S_EXEC) && (op == OP_LOAD) && (int'(entry_index) < MAX_FRAMES);
  assign tbl_rd = (state == S_POS);

  sfs_table_mem #(
    .DEPTH (MAX_FRAMES)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (AW'(entry_index)),
    .wr_data (entry_value),
    .rd_en   (tbl_rd),
    .rd_addr (AW'((play_index >= list_len) ? (list_len - 7'd1) : play_index)),
    .rd_data (tbl_data)
  );

  // coordinate unit
  logic       frame_sel_valid;
  logic [5:0] frame_next;
  coord_req_t coord_req;
  coord_rsp_t coord_rsp;

  always_comb begin
    if (list_len == 7'd0) begin
      frame_next = range_start;             // empty list reports the range start
    end else if (play_mode[MODE_CUSTOM]) begin
      frame_next = tbl_data;
    end else begin
      frame_next = range_frame;
    end
  end

  assign frame_sel_valid = (state == S_FRAME);
  assign coord_req = '{frame:  frame_next,
                       across: frames_across,
                       width:  frame_width,
                       height: frame_height};

  sfs_coord_unit u_coord (
    .clk   (clk),
    .rst   (rst),
    .start (frame_sel_valid),
    .req   (coord_req),
    .rsp   (coord_rsp)
  );

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= 10'd1;
      frame_height  <= 10'd1;
      frames_across <= 7'd1;
      frame_period  <= 16'd1;
      range_start   <= 6'd0;
      range_end     <= 6'd0;
      play_mode     <= 3'd0;
      custom_length <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:   frame_width   <= cfg_data[9:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data[9:0];
        REG_FRAMES_ACROSS: frames_across <= cfg_data[6:0];
        REG_FRAME_PERIOD:  frame_period  <= cfg_data;
        REG_RANGE_START:   range_start   <= cfg_data[5:0];
        REG_RANGE_END:     range_end     <= cfg_data[5:0];
        REG_PLAY_MODE:     play_mode     <= cfg_data[2:0];
        REG_CUSTOM_LENGTH: custom_length <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);

  // request capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op          <= s_tuser;
      elapsed     <= s_tdata[15:0];
      entry_index <= s_tdata[21:16];
      entry_value <= s_tdata[27:22];
    end
  end

  // sequence and animation state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      time_accum  <= 17'd0;
      play_index  <= 7'd0;
      running     <= 1'b0;
      adv_pending <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          list_len    <= len_next;
          adv_pending <= 1'b0;
          unique case (op)
            OP_TICK: begin
              if (running) begin
                if (len_next == 7'd0) begin
                  running    <= 1'b0;
                  play_index <= 7'd0;
                end else begin
                  time_accum  <= accum_sat;
                  adv_pending <= 1'b1;
                end
              end
            end
            OP_START: begin
              play_index <= 7'd0;
              running    <= (len_next != 7'd0);
            end
            OP_STOP: begin
              running    <= 1'b0;
              play_index <= 7'd0;
            end
            OP_PAUSE:  running <= 1'b0;
            OP_RESUME: running <= (len_next != 7'd0);
            default: ;                       // load goes to the table, others do nothing
          endcase
          state <= S_ADV;
        end
        S_ADV: begin
          if (adv_pending && (time_accum >= {1'b0, frame_period})) begin
            time_accum <= time_accum - {1'b0, frame_period};
            if (index_inc >= {1'b0, list_len}) begin
              if (play_mode[MODE_LOOP]) begin
                play_index <= 7'd0;
              end else begin
                play_index <= list_len - 7'd1;
                running    <= 1'b0;
              end
            end else begin
              play_index <= index_inc[6:0];
            end
          end
          state <= S_POS;
        end
        S_POS: begin
          // a position past a shrunk list reads the last entry
          pos   <= (play_index >= list_len) ? (list_len - 7'd1) : play_index;
          state <= S_FRAME;
        end
        S_FRAME: begin
          frame <= frame_next;
          state <= S_COORD;
        end
        S_COORD: begin
          if (coord_rsp.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
      m_tdata <= {2'b00, play_index, running, coord_rsp.y, coord_rsp.x, frame};
    end
  end

endmodule

>>> sv/sfs_table_mem.sv
// ----------------------------------------------------------------------------
// sfs_table_mem
// custom play table, one write and one registered read port
// ----------------------------------------------------------------------------
module sfs_table_mem #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [5:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [5:0]               rd_data
);

  logic [5:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/sfs_coord_unit.sv
// ----------------------------------------------------------------------------
// sfs_coord_unit
// sheet coordinates of a frame: bit-serial column/row split, then two products
// ----------------------------------------------------------------------------
module sfs_coord_unit
  import sfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  coord_req_t req,
  output coord_rsp_t rsp
);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_DIV  = 3'b010,
    C_MUL  = 3'b100
  } cstate_t;

  cstate_t     state;
  logic [6:0]  divisor;
  logic [6:0]  rem;
  logic [5:0]  dvd;
  logic [5:0]  quot;
  logic [2:0]  cnt;
  logic [9:0]  width_r;
  logic [9:0]  height_r;
  logic [7:0]  trial;
  logic        fits;
  logic        done_r;
  logic [15:0] x_r;
  logic [15:0] y_r;

  assign trial = {rem, dvd[5]};
  assign fits  = trial >= {1'b0, divisor};
  assign rsp   = '{done: done_r, x: x_r, y: y_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            state <= C_DIV;
          end
        end
        C_DIV: begin
          if (cnt == 3'd5) begin
            state <= C_MUL;
          end
        end
        C_MUL: begin
          done_r <= 1'b1;
          state  <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      C_IDLE: begin
        if (start) begin
          // zero frames across counts as one
          divisor  <= (req.across == 7'd0) ? 7'd1 : req.across;
          rem      <= 7'd0;
          dvd      <= req.frame;
          quot     <= 6'd0;
          cnt      <= 3'd0;
          width_r  <= req.width;
          height_r <= req.height;
        end
      end
      C_DIV: begin
        // one quotient bit a cycle
        rem  <= fits ? 7'(trial - {1'b0, divisor}) : trial[6:0];
        quot <= {quot[4:0], fits};
        dvd  <= {dvd[4:0], 1'b0};
        cnt  <= cnt + 3'd1;
      end
      C_MUL: begin
        // remainder never exceeds the frame number, so six bits hold it
        x_r <= {10'd0, rem[5:0]} * {6'd0, width_r};
        y_r <= {10'd0, quot} * {6'd0, height_r};
      end
      default: ;
    endcase
  end

endmodule

>>> sv/sfs_checker.sv
// ----------------------------------------------------------------------------
// sfs_checker
// port-level checks of the sprite frame sequencer
// ----------------------------------------------------------------------------
module sfs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // outputs start empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one request in flight at a time
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while another is in flight");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // frame zero sits at the sheet origin
  a_origin: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[5:0] == 6'd0)) |-> (m_tdata[37:6] == 32'd0))
    else $error("frame zero away from origin");

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
